// ===== hdl/rgbc_pkg.sv =====
// ---------------------------------------------------------------------------
// rgbc_pkg
// Shared widths, constants and types of the color sample to HSL converter.
// ---------------------------------------------------------------------------
package rgbc_pkg;

   // field widths
   localparam int COUNT_W = 16;
   localparam int PCT_W   = 7;
   localparam int HUE_W   = 9;
   localparam int SUM_W   = 8;

   // scaled count width: a 16-bit count times 100
   localparam int SCALED_W = 23;
   // hue numerator width: 60 times a percent difference
   localparam int HNUM_W   = 13;
   // saturation numerator width: 100 times a percent difference
   localparam int SNUM_W   = 14;

   // pipelined divider depth, one quotient bit per stage
   localparam int DIV_STAGES = 7;

   // beat widths on the stream ports
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;

   // arithmetic constants
   localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
   localparam logic [PCT_W-1:0] LIGHT_HALF = 7'd50;
   localparam logic [SUM_W-1:0] SUM_FULL   = 8'd200;
   localparam logic [5:0]       HUE_SCALE  = 6'd60;
   localparam logic [HUE_W-1:0] HUE_GREEN  = 9'd120;
   localparam logic [HUE_W-1:0] HUE_BLUE   = 9'd240;
   localparam logic [HUE_W-1:0] HUE_WRAP   = 9'd360;

   // which channel holds the maximum
   typedef enum logic [1:0] {
      SECT_RED   = 2'd0,
      SECT_GREEN = 2'd1,
      SECT_BLUE  = 2'd2
   } sector_type;

   // flags traveling beside the percent dividers
   typedef struct packed {
      logic no_light;
      logic red_sat;
      logic green_sat;
      logic blue_sat;
   } pct_side_type;

   // flags traveling beside the hue and saturation dividers
   typedef struct packed {
      logic             no_light;
      logic             gray;
      sector_type       sector;
      logic             neg;
      logic [PCT_W-1:0] light;
   } hsl_side_type;

endpackage

// ===== hdl/rgbc_to_hsl_converter.sv =====
// ---------------------------------------------------------------------------
// rgbc_to_hsl_converter
// Converts clear, red, green and blue sensor counts into integer HSL.
// ---------------------------------------------------------------------------
// The req_ channel takes one sensor sample per beat; the rsp_ channel returns
// one HSL result per sample, in order. Each color count is turned into a
// percent of the clear count, then hue, saturation and lightness follow.
// A zero clear count gives all zero fields with rsp_tuser high.
// An accepted req_ beat passes an input register, a 7-stage percent divider,
// two compare stages, a 7-stage hue/saturation divider and the output
// register on its way to rsp_tvalid. Throughput is one beat per cycle when
// not stalled; every stage is a register, no unit is shared across cycles.
// The whole pipeline advances whenever the output register is empty or
// being taken, so req_tready stays high while rsp_tready is high, and a
// waiting result does not block acceptance while the output is free.
// When the receiver stalls with a result waiting, the pipeline freezes:
// req_tready drops and nothing is lost or repeated.
// Reset clears all valid bits; no result is shown until a new sample
// has passed through.
// ---------------------------------------------------------------------------
module rgbc_to_hsl_converter (
   input  logic                               clock,
   input  logic                               reset,
   // clear[15:0], red[31:16], green[47:32], blue[63:48]
   input  logic [rgbc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // hue_deg[8:0], saturation_pct[15:9], lightness_pct[22:16], zero[23]
   output logic [rgbc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // no_light[0]
   output logic                               rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready
);

   import rgbc_pkg::*;

   logic en;

   // input register
   logic               in_valid_ff;
   logic [COUNT_W-1:0] clear_ff, red_ff, green_ff, blue_ff;

   // percent stage
   pct_side_type       pct_side_in, pct_side;
   logic               pct_valid;
   logic [PCT_W-1:0]   red_q, green_q, blue_q;

   // stage a: percents
   logic               a_valid_ff;
   logic               a_zero_ff;
   logic [PCT_W-1:0]   a_red_ff, a_green_ff, a_blue_ff;

   // stage b: max, min and sector
   logic [PCT_W-1:0]   mx, mn, mag;
   sector_type         sector;
   logic               neg;
   logic [SUM_W-1:0]   sum;
   logic [PCT_W-1:0]   light;
   logic               b_valid_ff;
   hsl_side_type       b_side_ff, b_side_in;
   logic [PCT_W-1:0]   b_dif_ff, b_mag_ff;
   logic [SUM_W-1:0]   b_den_ff, b_den_in;

   // hue and saturation dividers
   logic [HNUM_W-1:0]  hue_num;
   logic [SNUM_W-1:0]  sat_num;
   logic [PCT_W-1:0]   hue_q, sat_q;
   logic               hsl_valid;
   hsl_side_type       hsl_side;

   // output
   logic [HUE_W-1:0]   hue_base, hue_val;
   logic               rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic               rsp_tuser_ff, rsp_tuser_in;

   // the pipeline moves when the output register can take a beat
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         clear_ff <= req_tdata[15:0];
         red_ff   <= req_tdata[31:16];
         green_ff <= req_tdata[47:32];
         blue_ff  <= req_tdata[63:48];
      end
   end

   // count over clear, scaled by 100; a count at or above clear saturates
   rgbc_udiv #(.NUM_W(SCALED_W), .DEN_W(COUNT_W), .QUO_W(DIV_STAGES)) u_div_red (
      .clock (clock), .en_i (en),
      .num_i (SCALED_W'(red_ff) * SCALED_W'(PCT_FULL)),
      .den_i (clear_ff), .quot_o (red_q)
   );
   rgbc_udiv #(.NUM_W(SCALED_W), .DEN_W(COUNT_W), .QUO_W(DIV_STAGES)) u_div_green (
      .clock (clock), .en_i (en),
      .num_i (SCALED_W'(green_ff) * SCALED_W'(PCT_FULL)),
      .den_i (clear_ff), .quot_o (green_q)
   );
   rgbc_udiv #(.NUM_W(SCALED_W), .DEN_W(COUNT_W), .QUO_W(DIV_STAGES)) u_div_blue (
      .clock (clock), .en_i (en),
      .num_i (SCALED_W'(blue_ff) * SCALED_W'(PCT_FULL)),
      .den_i (clear_ff), .quot_o (blue_q)
   );

   always_comb begin
      pct_side_in.no_light  = (clear_ff == '0);
      pct_side_in.red_sat   = (red_ff >= clear_ff);
      pct_side_in.green_sat = (green_ff >= clear_ff);
      pct_side_in.blue_sat  = (blue_ff >= clear_ff);
   end

   rgbc_delay #(.WIDTH($bits(pct_side_type)), .DEPTH(DIV_STAGES)) u_dly_pct (
      .clock (clock), .reset (reset), .en_i (en),
      .valid_i (in_valid_ff), .data_i (pct_side_in),
      .valid_o (pct_valid), .data_o (pct_side)
   );

   // stage a: clamp percents
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= pct_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_zero_ff  <= pct_side.no_light;
         a_red_ff   <= pct_side.red_sat   ? PCT_FULL : red_q;
         a_green_ff <= pct_side.green_sat ? PCT_FULL : green_q;
         a_blue_ff  <= pct_side.blue_sat  ? PCT_FULL : blue_q;
      end
   end

   // stage b: max, min, sector and hue numerator magnitude; ties favor red then green
   always_comb begin
      mx = a_red_ff;
      if (a_green_ff > mx) mx = a_green_ff;
      if (a_blue_ff > mx)  mx = a_blue_ff;
      mn = a_red_ff;
      if (a_green_ff < mn) mn = a_green_ff;
      if (a_blue_ff < mn)  mn = a_blue_ff;
      sum   = SUM_W'(mx) + SUM_W'(mn);
      light = sum[SUM_W-1:1];
      if (mx == a_red_ff) begin
         sector = SECT_RED;
         neg    = (a_green_ff < a_blue_ff);
         mag    = neg ? (a_blue_ff - a_green_ff) : (a_green_ff - a_blue_ff);
      end else if (mx == a_green_ff) begin
         sector = SECT_GREEN;
         neg    = (a_blue_ff < a_red_ff);
         mag    = neg ? (a_red_ff - a_blue_ff) : (a_blue_ff - a_red_ff);
      end else begin
         sector = SECT_BLUE;
         neg    = (a_red_ff < a_green_ff);
         mag    = neg ? (a_green_ff - a_red_ff) : (a_red_ff - a_green_ff);
      end
      b_den_in = (light <= LIGHT_HALF) ? sum : (SUM_FULL - sum);
      b_side_in.no_light = a_zero_ff;
      b_side_in.gray     = (mx == mn);
      b_side_in.sector   = sector;
      b_side_in.neg      = neg;
      b_side_in.light    = light;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_side_ff <= b_side_in;
         b_dif_ff  <= mx - mn;
         b_mag_ff  <= mag;
         b_den_ff  <= b_den_in;
      end
   end

   // hue and saturation quotients
   assign hue_num = HNUM_W'(b_mag_ff) * HNUM_W'(HUE_SCALE);
   assign sat_num = SNUM_W'(b_dif_ff) * SNUM_W'(PCT_FULL);

   rgbc_udiv #(.NUM_W(HNUM_W), .DEN_W(PCT_W), .QUO_W(DIV_STAGES)) u_div_hue (
      .clock (clock), .en_i (en),
      .num_i (hue_num), .den_i (b_dif_ff), .quot_o (hue_q)
   );
   rgbc_udiv #(.NUM_W(SNUM_W), .DEN_W(SUM_W), .QUO_W(DIV_STAGES)) u_div_sat (
      .clock (clock), .en_i (en),
      .num_i (sat_num), .den_i (b_den_ff), .quot_o (sat_q)
   );

   rgbc_delay #(.WIDTH($bits(hsl_side_type)), .DEPTH(DIV_STAGES)) u_dly_hsl (
      .clock (clock), .reset (reset), .en_i (en),
      .valid_i (b_valid_ff), .data_i (b_side_ff),
      .valid_o (hsl_valid), .data_o (hsl_side)
   );

   // hue offset by sector; a negative quotient in the red sector wraps by 360
   always_comb begin
      case (hsl_side.sector)
         SECT_RED:   hue_base = hsl_side.neg ? HUE_WRAP : '0;
         SECT_GREEN: hue_base = HUE_GREEN;
         SECT_BLUE:  hue_base = HUE_BLUE;
         default:    hue_base = '0;
      endcase
      hue_val = hsl_side.neg ? (hue_base - HUE_W'(hue_q)) : (hue_base + HUE_W'(hue_q));
      if (hsl_side.no_light) begin
         rsp_tdata_in = '0;
      end else if (hsl_side.gray) begin
         rsp_tdata_in = {1'b0, hsl_side.light, PCT_W'(0), HUE_W'(0)};
      end else begin
         rsp_tdata_in = {1'b0, hsl_side.light, sat_q, hue_val};
      end
      rsp_tuser_in = hsl_side.no_light;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= hsl_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // no sample is taken while a result waits on a stalled receiver
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("sample accepted while output stalled");

   // a dark sample reports all fields zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("no_light result with nonzero fields");

   // result fields stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[8:0] <= HUE_WRAP && rsp_tdata[15:9] <= PCT_FULL
                      && rsp_tdata[22:16] <= PCT_FULL))
      else $error("result field out of range");

   // zero saturation with zero lightness needs hue 0: gray or dark gives hue 0
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[15:9] == '0) |-> (rsp_tdata[8:0] == '0 ||
                                                 rsp_tdata[22:16] != '0))
      else $error("hue set on a zero-saturation result");

endmodule

// ===== hdl/rgbc_udiv.sv =====
// ---------------------------------------------------------------------------
// rgbc_udiv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// The numerator must be below the denominator shifted by the quotient width.
// ---------------------------------------------------------------------------
module rgbc_udiv #(
   parameter int NUM_W = 23,
   parameter int DEN_W = 16,
   parameter int QUO_W = 7
) (
   input  logic             clock,
   input  logic             en_i,
   input  logic [NUM_W-1:0] num_i,
   input  logic [DEN_W-1:0] den_i,
   output logic [QUO_W-1:0] quot_o
);

   localparam int EXT_W = NUM_W + DEN_W + QUO_W;

   logic [NUM_W-1:0] rem_ff [QUO_W-1];
   logic [DEN_W-1:0] den_ff [QUO_W-1];
   logic [QUO_W-1:0] quot_ff [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int SH = QUO_W - 1 - s;

      logic [NUM_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] quot_prev;
      logic [EXT_W-1:0] rem_ext;
      logic [EXT_W-1:0] den_sh;
      logic             ge;
      logic [QUO_W-1:0] quot_in;

      // pick up the previous stage
      if (s == 0) begin : g_first
         assign rem_prev  = num_i;
         assign den_prev  = den_i;
         assign quot_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign quot_prev = quot_ff[s-1];
      end

      // trial subtract of the shifted divisor
      assign rem_ext = EXT_W'(rem_prev);
      assign den_sh  = EXT_W'(den_prev) << SH;
      assign ge      = (rem_ext >= den_sh);
      assign quot_in = quot_prev | (QUO_W'(ge) << SH);

      always_ff @(posedge clock) begin
         if (en_i) begin
            quot_ff[s] <= quot_in;
         end
      end

      // remainder and divisor are needed only by later stages
      if (s < QUO_W - 1) begin : g_carry
         logic [NUM_W-1:0] rem_in;

         assign rem_in = ge ? NUM_W'(rem_ext - den_sh) : rem_prev;

         always_ff @(posedge clock) begin
            if (en_i) begin
               rem_ff[s] <= rem_in;
               den_ff[s] <= den_prev;
            end
         end
      end
   end

   assign quot_o = quot_ff[QUO_W-1];

endmodule

// ===== hdl/rgbc_delay.sv =====
// ---------------------------------------------------------------------------
// rgbc_delay
// Valid bit and side flags delayed to line up with a divider pipeline.
// ---------------------------------------------------------------------------
module rgbc_delay #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en_i,
   input  logic             valid_i,
   input  logic [WIDTH-1:0] data_i,
   output logic             valid_o,
   output logic [WIDTH-1:0] data_o
);

   logic             valid_ff [DEPTH];
   logic [WIDTH-1:0] data_ff  [DEPTH];

   for (genvar s = 0; s < DEPTH; s++) begin : g_tap
      logic             valid_prev;
      logic [WIDTH-1:0] data_prev;

      if (s == 0) begin : g_first
         assign valid_prev = valid_i;
         assign data_prev  = data_i;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign data_prev  = data_ff[s-1];
      end

      // valid is control state and clears on reset
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en_i) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en_i) begin
            data_ff[s] <= data_prev;
         end
      end
   end

   assign valid_o = valid_ff[DEPTH-1];
   assign data_o  = data_ff[DEPTH-1];

endmodule

// ===== test/rgbc_to_hsl_converter_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgbc_to_hsl_converter_test
// Self-checking bench for the sensor count to HSL converter: directed corner
// samples and random samples are streamed in under varied back-pressure and
// every result beat is compared with an in-bench HSL calculation.
// ---------------------------------------------------------------------------
module rgbc_to_hsl_converter_test;
   import rgbc_pkg::*;

   typedef struct packed {
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
      logic [15:0] clear;
   } sample_type;

   typedef struct {
      logic [8:0] hue;
      logic [6:0] sat;
      logic [6:0] light;
      logic       dark;
   } hsl_type;

   localparam int PHASE_LEN = 320;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;

   sample_type pending_samples[$];
   hsl_type    expected_hsl[$];
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  error_count = 0;

   rgbc_to_hsl_converter uut (.*);

   always #10 clock = ~clock;

   // percent of clear, clipped at full scale
   function automatic int percent_of(int count, int clear);
      int p;
      p = (count * 100) / clear;
      return (p > 100) ? 100 : p;
   endfunction

   function automatic hsl_type convert_sample(sample_type s);
      hsl_type res;
      int r, g, b, mx, mn, dif, sum, hue, sat;
      res = '{hue: '0, sat: '0, light: '0, dark: 1'b1};
      if (s.clear == 0) return res;
      r = percent_of(s.red, s.clear);
      g = percent_of(s.green, s.clear);
      b = percent_of(s.blue, s.clear);
      mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
      mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
      dif = mx - mn;
      sum = mx + mn;
      hue = 0;
      sat = 0;
      if (dif != 0) begin
         // int division truncates toward zero, as required for hue
         if (mx == r) begin
            hue = (60 * (g - b)) / dif;
            if (g < b) hue += 360;
         end else if (mx == g) begin
            hue = (60 * (b - r)) / dif + 120;
         end else begin
            hue = (60 * (r - g)) / dif + 240;
         end
         if (sum / 2 <= 50) sat = (dif * 100) / sum;
         else sat = (dif * 100) / (200 - sum);
      end
      res.hue = hue[8:0];
      res.sat = sat[6:0];
      res.light = 7'(sum / 2);
      res.dark = 1'b0;
      return res;
   endfunction

   function automatic sample_type make_sample(int c, int r, int g, int b);
      sample_type s;
      s.clear = c[15:0]; s.red = r[15:0]; s.green = g[15:0]; s.blue = b[15:0];
      return s;
   endfunction

   // random sample, mostly with colors between zero and the clear count
   function automatic sample_type random_sample();
      sample_type s;
      int c;
      case ($urandom_range(0, 9))
         0: s = sample_type'({$urandom, $urandom});
         1: s = make_sample(0, $urandom, $urandom, $urandom);
         2: begin
            c = $urandom_range(1, 8);
            s = make_sample(c, $urandom_range(0, 9), $urandom_range(0, 9),
                            $urandom_range(0, 9));
         end
         default: begin
            c = $urandom_range(1, 65535);
            s = make_sample(c, $urandom_range(0, c), $urandom_range(0, c),
                            $urandom_range(0, c));
            if ($urandom_range(0, 5) == 0) s.red = s.green;
            if ($urandom_range(0, 5) == 0) s.blue = s.green;
         end
      endcase
      return s;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) expected_hsl.push_back(convert_sample(sample_type'(req_tdata)));
         if (pending_samples.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
            req_tdata  <= pending_samples.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      hsl_type exp_hsl;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hsl.size() == 0) begin
               $error("unexpected result beat %h", rsp_tdata);
               error_count++;
            end else begin
               exp_hsl = expected_hsl.pop_front();
               if (rsp_tdata[8:0] !== exp_hsl.hue) begin
                  $error("hue_deg exp %0d got %0d", exp_hsl.hue, rsp_tdata[8:0]);
                  error_count++;
               end
               if (rsp_tdata[15:9] !== exp_hsl.sat) begin
                  $error("saturation_pct exp %0d got %0d", exp_hsl.sat, rsp_tdata[15:9]);
                  error_count++;
               end
               if (rsp_tdata[22:16] !== exp_hsl.light) begin
                  $error("lightness_pct exp %0d got %0d", exp_hsl.light,
                         rsp_tdata[22:16]);
                  error_count++;
               end
               if (rsp_tuser !== exp_hsl.dark) begin
                  $error("no_light exp %0d got %0d", exp_hsl.dark, rsp_tuser);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(1, 100) > stall_pct);
      end
   end

   // stimulus
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // directed corners
      pending_samples.push_back(make_sample(0, 0, 0, 0));
      pending_samples.push_back(make_sample(0, 65535, 65535, 65535));
      pending_samples.push_back(make_sample(65535, 0, 0, 0));
      pending_samples.push_back(make_sample(65535, 65535, 65535, 65535));
      pending_samples.push_back(make_sample(1, 65535, 0, 0));
      pending_samples.push_back(make_sample(1, 0, 65535, 0));
      pending_samples.push_back(make_sample(1, 0, 0, 65535));
      pending_samples.push_back(make_sample(100, 50, 50, 50));
      pending_samples.push_back(make_sample(100, 80, 20, 21));
      pending_samples.push_back(make_sample(100, 100, 0, 1));
      pending_samples.push_back(make_sample(100, 90, 90, 10));
      pending_samples.push_back(make_sample(100, 10, 90, 90));
      pending_samples.push_back(make_sample(100, 90, 10, 90));
      pending_samples.push_back(make_sample(100, 70, 40, 10));
      pending_samples.push_back(make_sample(100, 30, 60, 90));
      pending_samples.push_back(make_sample(100, 95, 60, 70));
      pending_samples.push_back(make_sample(100, 10, 20, 15));
      pending_samples.push_back(make_sample(3, 2, 1, 0));
      pending_samples.push_back(make_sample(65535, 65535, 32768, 1));
      pending_samples.push_back(make_sample(40000, 60000, 100, 50000));
      // random phases: none, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 77 : (ph == 3) ? 18 : 0;
         stall_pct     = (ph == 2) ? 77 : (ph == 3) ? 18 : 0;
         for (int i = 0; i < PHASE_LEN; i++) pending_samples.push_back(random_sample());
         wait (pending_samples.size() == 0 && !req_tvalid);
      end
      wait (expected_hsl.size() == 0);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rgbc_pkg.sv
hdl/rgbc_udiv.sv
hdl/rgbc_delay.sv
hdl/rgbc_to_hsl_converter.sv
test/rgbc_to_hsl_converter_test.sv
